FILE: hdl/pcbs_pkg.sv
`timescale 1ns / 1ps

package pcbs_pkg;

	localparam int MAX_PARTICLES = 4096;
	localparam int POSITION_BITS = 16;
	localparam int ADDR_W = $clog2(MAX_PARTICLES);
	localparam int CNT_W = ADDR_W + 1;
	localparam int FRAC_SHIFT = 24 - POSITION_BITS;
	localparam int REC_W = 3 * POSITION_BITS + 3 * 32 + 16;

	localparam logic [1:0] REG_PARTICLE_COUNT = 2'd0;
	localparam logic [1:0] REG_SOFTENING_FLOOR = 2'd1;
	localparam logic [1:0] REG_SPEED_CLAMP = 2'd2;

	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_COMPUTE = 1'b1;

	localparam logic [12:0] PARTICLE_COUNT_RST = 13'd0;
	localparam logic [31:0] SOFTENING_FLOOR_RST = 32'd42949673;
	localparam logic [30:0] SPEED_CLAMP_RST = 31'd65536000;

	typedef struct packed {
		logic               command;
		logic [11:0]        particle_index;
		logic [15:0]        pos_x;
		logic [15:0]        pos_y;
		logic [15:0]        pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [15:0] charge;
	} item_t;

	typedef struct packed {
		logic [11:0]        target_index;
		logic signed [63:0] e_x;
		logic signed [63:0] e_y;
		logic signed [63:0] e_z;
		logic signed [63:0] b_x;
		logic signed [63:0] b_y;
		logic signed [63:0] b_z;
	} result_t;

endpackage

FILE: hdl/pcbs_ram.sv
`timescale 1ns / 1ps

module pcbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: hdl/pairwise_coulomb_biot_savart_field_sum.sv
// Direct-sum Coulomb and Biot-Savart field unit for particles in a periodic unit box.
// Item channel (item_valid / item_stall / item): a store transaction writes one source
// particle into the particle memory in the cycle it is taken and returns nothing. A
// compute transaction names a target and produces exactly one result transaction on
// the result channel (result_valid / result_stall / result) with the summed fields.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data) is always ready;
// write it only while no compute is in flight.
// A store leaves the item channel free for the next item. A compute sums over the sources
// below particle_count other than the target; each source with a nonzero floored distance
// runs through the one shared 32x32 multiplier, a 32-step square root and an 81-step
// reciprocal, and every source is fetched from the single-port-read particle memory.
// The item channel stalls for the whole compute.
// The result sits in an output register; a new item is taken while it waits, and only the
// hand-off of the next result waits on a stalled receiver.
// Reset clears the sequencer, the result valid flag and the configuration registers to
// their defaults; the particle memory is not cleared and must be written before use.
`timescale 1ns / 1ps

module pairwise_coulomb_biot_savart_field_sum
	import pcbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// sequencer codes
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_TGT   = 4'd1;
	localparam logic [3:0] ST_NEXT  = 4'd2;
	localparam logic [3:0] ST_LOAD  = 4'd3;
	localparam logic [3:0] ST_SQ    = 4'd4;
	localparam logic [3:0] ST_FLOOR = 4'd5;
	localparam logic [3:0] ST_SQRT  = 4'd6;
	localparam logic [3:0] ST_RS    = 4'd7;
	localparam logic [3:0] ST_RECIP = 4'd8;
	localparam logic [3:0] ST_CROSS = 4'd9;
	localparam logic [3:0] ST_XMUL  = 4'd10;
	localparam logic [3:0] ST_WMUL  = 4'd11;
	localparam logic [3:0] ST_ACC   = 4'd12;
	localparam logic [3:0] ST_DONE  = 4'd13;

	// particle record layout: {pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, charge}
	localparam int OFS_Q  = 0;
	localparam int OFS_VZ = 16;
	localparam int OFS_VY = 48;
	localparam int OFS_VX = 80;
	localparam int OFS_PZ = 112;
	localparam int OFS_PY = OFS_PZ + POSITION_BITS;
	localparam int OFS_PX = OFS_PY + POSITION_BITS;

	localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};

	// Wrapped separation scaled to Q0.24: returns {negative, magnitude}.
	function automatic logic [24:0] sep(input logic [POSITION_BITS-1:0] t,
			input logic [POSITION_BITS-1:0] s);
		logic [POSITION_BITS-1:0] w;
		logic signed [23:0] d;
		logic [23:0] m;
		w = t - s;
		d = 24'(signed'(w));
		d = d <<< FRAC_SHIFT;
		m = d[23] ? 24'(-d) : 24'(d);
		sep = {d[23], m};
	endfunction

	// Velocity magnitude clamped to the speed limit.
	function automatic logic [30:0] clamp_mag(input logic [31:0] v, input logic [30:0] c);
		logic [31:0] a;
		a = v[31] ? (~v + 32'd1) : v;
		clamp_mag = (a > {1'b0, c}) ? c : a[30:0];
	endfunction

	// control state
	logic [3:0]       state_q, state_d;
	logic [2:0]       step_q, step_d;
	logic [2:0]       term_q, term_d;
	logic [6:0]       iter_q, iter_d;
	logic [CNT_W-1:0] j_q, j_d;
	logic             result_valid_q;
	logic [12:0]      particle_count_q;
	logic [31:0]      softening_floor_q;
	logic [30:0]      speed_clamp_q;

	// datapath
	logic [11:0]              idx_q;
	logic [ADDR_W-1:0]        tgt_addr_q;
	logic [CNT_W-1:0]         n_q;
	logic [POSITION_BITS-1:0] tx_q, ty_q, tz_q;
	logic [23:0]              dmx_q, dmy_q, dmz_q;
	logic                     dnx_q, dny_q, dnz_q;
	logic [30:0]              vmx_q, vmy_q, vmz_q;
	logic                     vnx_q, vny_q, vnz_q;
	logic [15:0]              qmag_q;
	logic                     qneg_q;
	logic [47:0]              sum_q;
	logic [31:0]              r_q;
	logic [63:0]              sq_n_q, sq_res_q, sq_bit_q;
	logic [63:0]              dv_q, rem_q, quo_q;
	logic                     over_q;
	logic signed [56:0]       cr_acc_q;
	logic [39:0]              crx_q, cry_q, crz_q;
	logic                     cnx_q, cny_q, cnz_q;
	logic [55:0]              x_mag_q;
	logic                     x_neg_q;
	logic [119:0]             p_q;
	logic signed [63:0]       acc_q [6];
	result_t                  result_q;

	// memory ports
	logic              wr_en, rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [REC_W-1:0]  wr_data, rd_data;

	logic idx_ok, take_compute, out_free;
	logic [CNT_W-1:0] n_d;

	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic        mul_neg;

	logic [31:0]        r_raw, r_floor;
	logic [63:0]        sq_trial;
	logic [63:0]        rem_sh;
	logic               rc_take;
	logic [63:0]        w_val;
	logic signed [56:0] prod_s, cr_val, cr_abs;
	logic [62:0]        mag63;
	logic signed [63:0] term_val, acc_sel, acc_new;
	logic signed [64:0] acc_sum;
	logic [24:0]        sx, sy, sz;

	assign idx_ok = int'(item.particle_index) < MAX_PARTICLES;
	assign take_compute = (state_q == ST_IDLE) && item_valid && (item.command == CMD_COMPUTE);
	assign out_free = !result_valid_q || !result_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign result_valid = result_valid_q;
	assign result = result_q;

	always_comb begin
		if (int'(particle_count_q) > MAX_PARTICLES) begin
			n_d = CNT_W'(MAX_PARTICLES);
		end else begin
			n_d = CNT_W'(particle_count_q);
		end
	end

	// store straight into memory; reads fetch the target, then each source
	assign wr_en = (state_q == ST_IDLE) && item_valid && (item.command == CMD_STORE) && idx_ok;
	assign wr_data = {item.pos_x[POSITION_BITS-1:0], item.pos_y[POSITION_BITS-1:0],
		item.pos_z[POSITION_BITS-1:0], item.vel_x, item.vel_y, item.vel_z, item.charge};
	assign rd_en = take_compute || (state_q == ST_NEXT);
	assign rd_addr = take_compute ? ADDR_W'(item.particle_index) : j_q[ADDR_W-1:0];

	pcbs_ram #(
		.WIDTH(REC_W),
		.DEPTH(MAX_PARTICLES)
	) u_particle_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(ADDR_W'(item.particle_index)),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign sx = sep(tx_q, rd_data[OFS_PX +: POSITION_BITS]);
	assign sy = sep(ty_q, rd_data[OFS_PY +: POSITION_BITS]);
	assign sz = sep(tz_q, rd_data[OFS_PZ +: POSITION_BITS]);

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mul_neg = 1'b0;
		unique case (state_q)
			ST_SQ: begin
				unique case (step_q)
					3'd0: begin mul_a = {8'b0, dmx_q}; mul_b = {8'b0, dmx_q}; end
					3'd1: begin mul_a = {8'b0, dmy_q}; mul_b = {8'b0, dmy_q}; end
					default: begin mul_a = {8'b0, dmz_q}; mul_b = {8'b0, dmz_q}; end
				endcase
			end
			ST_RS: begin
				mul_a = r_q;
				mul_b = sq_res_q[31:0];
			end
			ST_CROSS: begin
				unique case (step_q)
					3'd0: begin mul_a = {1'b0, vmy_q}; mul_b = {8'b0, dmz_q}; mul_neg = vny_q ^ dnz_q; end
					3'd1: begin mul_a = {1'b0, vmz_q}; mul_b = {8'b0, dmy_q}; mul_neg = vnz_q ^ dny_q; end
					3'd2: begin mul_a = {1'b0, vmz_q}; mul_b = {8'b0, dmx_q}; mul_neg = vnz_q ^ dnx_q; end
					3'd3: begin mul_a = {1'b0, vmx_q}; mul_b = {8'b0, dmz_q}; mul_neg = vnx_q ^ dnz_q; end
					3'd4: begin mul_a = {1'b0, vmx_q}; mul_b = {8'b0, dmy_q}; mul_neg = vnx_q ^ dny_q; end
					default: begin mul_a = {1'b0, vmy_q}; mul_b = {8'b0, dmx_q}; mul_neg = vny_q ^ dnx_q; end
				endcase
			end
			ST_XMUL: begin
				mul_a = {16'b0, qmag_q};
				unique case (term_q)
					3'd0: mul_b = {8'b0, dmx_q};
					3'd1: mul_b = {8'b0, dmy_q};
					3'd2: mul_b = {8'b0, dmz_q};
					3'd3: mul_b = (step_q == 3'd0) ? crx_q[31:0] : {24'b0, crx_q[39:32]};
					3'd4: mul_b = (step_q == 3'd0) ? cry_q[31:0] : {24'b0, cry_q[39:32]};
					default: mul_b = (step_q == 3'd0) ? crz_q[31:0] : {24'b0, crz_q[39:32]};
				endcase
			end
			ST_WMUL: begin
				unique case (step_q)
					3'd0: begin mul_a = x_mag_q[31:0]; mul_b = w_val[31:0]; end
					3'd1: begin mul_a = x_mag_q[31:0]; mul_b = w_val[63:32]; end
					3'd2: begin mul_a = {8'b0, x_mag_q[55:32]}; mul_b = w_val[31:0]; end
					default: begin mul_a = {8'b0, x_mag_q[55:32]}; mul_b = w_val[63:32]; end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// per-pair arithmetic
	always_comb begin
		r_raw = sum_q[47:16];
		r_floor = (r_raw < softening_floor_q) ? softening_floor_q : r_raw;
		sq_trial = sq_res_q + sq_bit_q;
		rem_sh = {rem_q[62:0], (iter_q == 7'd0)};
		rc_take = rem_q[63] || (rem_sh >= dv_q);
		w_val = over_q ? {64{1'b1}} : quo_q;
		prod_s = mul_neg ? -$signed({2'b0, mul_p[54:0]}) : $signed({2'b0, mul_p[54:0]});
		cr_val = cr_acc_q - prod_s;
		cr_abs = cr_val[56] ? -cr_val : cr_val;
		// saturate the scaled term when anything lands above bit 62 after the shift
		mag63 = (|p_q[119:86]) ? {63{1'b1}} : p_q[85:23];
		term_val = x_neg_q ? -$signed({1'b0, mag63}) : $signed({1'b0, mag63});
		acc_sel = acc_q[term_q];
		acc_sum = {acc_sel[63], acc_sel} + {term_val[63], term_val};
		if (acc_sum[64] != acc_sum[63]) begin
			acc_new = acc_sum[64] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_new = acc_sum[63:0];
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		step_d = step_q;
		term_d = term_q;
		iter_d = iter_q;
		j_d = j_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take_compute) begin
					j_d = '0;
					state_d = idx_ok ? ST_TGT : ST_DONE;
				end
			end
			ST_TGT: state_d = ST_NEXT;
			ST_NEXT: begin
				if (j_q >= n_q) begin
					state_d = ST_DONE;
				end else if (j_q[ADDR_W-1:0] == tgt_addr_q) begin
					j_d = j_q + 1'b1;
				end else begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_SQ;
				step_d = '0;
			end
			ST_SQ: begin
				if (step_q == 3'd2) begin
					state_d = ST_FLOOR;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_FLOOR: begin
				// coincident pair with no floor adds nothing
				if (r_floor == '0) begin
					state_d = ST_NEXT;
					j_d = j_q + 1'b1;
				end else begin
					state_d = ST_SQRT;
					iter_d = '0;
				end
			end
			ST_SQRT: begin
				if (iter_q == 7'd31) begin
					state_d = ST_RS;
				end else begin
					iter_d = iter_q + 1'b1;
				end
			end
			ST_RS: begin
				state_d = ST_RECIP;
				iter_d = '0;
			end
			ST_RECIP: begin
				if (iter_q == 7'd80) begin
					state_d = ST_CROSS;
					step_d = '0;
				end else begin
					iter_d = iter_q + 1'b1;
				end
			end
			ST_CROSS: begin
				if (step_q == 3'd5) begin
					state_d = ST_XMUL;
					step_d = '0;
					term_d = '0;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_XMUL: begin
				if (term_q < 3'd3 || step_q == 3'd1) begin
					state_d = ST_WMUL;
					step_d = '0;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_WMUL: begin
				if (step_q == 3'd3) begin
					state_d = ST_ACC;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_ACC: begin
				if (term_q == 3'd5) begin
					state_d = ST_NEXT;
					j_d = j_q + 1'b1;
				end else begin
					term_d = term_q + 1'b1;
					step_d = '0;
					state_d = ST_XMUL;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			term_q <= '0;
			iter_q <= '0;
			j_q <= '0;
			result_valid_q <= 1'b0;
			particle_count_q <= PARTICLE_COUNT_RST;
			softening_floor_q <= SOFTENING_FLOOR_RST;
			speed_clamp_q <= SPEED_CLAMP_RST;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
			term_q <= term_d;
			iter_q <= iter_d;
			j_q <= j_d;
			// hold the result until the receiver takes it
			if (state_q == ST_DONE && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_PARTICLE_COUNT: particle_count_q <= cfg_data[12:0];
					REG_SOFTENING_FLOOR: softening_floor_q <= cfg_data;
					REG_SPEED_CLAMP: speed_clamp_q <= cfg_data[30:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (take_compute) begin
					idx_q <= item.particle_index;
					tgt_addr_q <= ADDR_W'(item.particle_index);
					n_q <= n_d;
					for (int i = 0; i < 6; i++) begin
						acc_q[i] <= '0;
					end
				end
			end
			ST_TGT: begin
				tx_q <= rd_data[OFS_PX +: POSITION_BITS];
				ty_q <= rd_data[OFS_PY +: POSITION_BITS];
				tz_q <= rd_data[OFS_PZ +: POSITION_BITS];
			end
			ST_LOAD: begin
				{dnx_q, dmx_q} <= sx;
				{dny_q, dmy_q} <= sy;
				{dnz_q, dmz_q} <= sz;
				vmx_q <= clamp_mag(rd_data[OFS_VX +: 32], speed_clamp_q);
				vmy_q <= clamp_mag(rd_data[OFS_VY +: 32], speed_clamp_q);
				vmz_q <= clamp_mag(rd_data[OFS_VZ +: 32], speed_clamp_q);
				vnx_q <= rd_data[OFS_VX + 31];
				vny_q <= rd_data[OFS_VY + 31];
				vnz_q <= rd_data[OFS_VZ + 31];
				qneg_q <= rd_data[OFS_Q + 15];
				qmag_q <= rd_data[OFS_Q + 15] ? 16'(-rd_data[OFS_Q +: 16]) : rd_data[OFS_Q +: 16];
				sum_q <= '0;
			end
			ST_SQ: sum_q <= sum_q + mul_p[47:0];
			ST_FLOOR: begin
				r_q <= r_floor;
				sq_n_q <= {r_floor, 32'b0};
				sq_res_q <= '0;
				sq_bit_q <= 64'h4000_0000_0000_0000;
			end
			ST_SQRT: begin
				// one result bit per cycle
				if (sq_n_q >= sq_trial) begin
					sq_n_q <= sq_n_q - sq_trial;
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			ST_RS: begin
				dv_q <= mul_p;
				rem_q <= '0;
				quo_q <= '0;
				over_q <= 1'b0;
			end
			ST_RECIP: begin
				// restoring divide of 2^80, one quotient bit per cycle
				rem_q <= rc_take ? (rem_sh - dv_q) : rem_sh;
				if (quo_q[63]) begin
					over_q <= 1'b1;
				end
				quo_q <= {quo_q[62:0], rc_take};
			end
			ST_CROSS: begin
				if (!step_q[0]) begin
					cr_acc_q <= prod_s;
				end else begin
					unique case (step_q)
						3'd1: begin crx_q <= cr_abs[55:16]; cnx_q <= cr_val[56]; end
						3'd3: begin cry_q <= cr_abs[55:16]; cny_q <= cr_val[56]; end
						default: begin crz_q <= cr_abs[55:16]; cnz_q <= cr_val[56]; end
					endcase
				end
			end
			ST_XMUL: begin
				unique case (term_q)
					3'd0: x_neg_q <= qneg_q ^ dnx_q;
					3'd1: x_neg_q <= qneg_q ^ dny_q;
					3'd2: x_neg_q <= qneg_q ^ dnz_q;
					3'd3: x_neg_q <= qneg_q ^ cnx_q;
					3'd4: x_neg_q <= qneg_q ^ cny_q;
					default: x_neg_q <= qneg_q ^ cnz_q;
				endcase
				if (step_q == 3'd0) begin
					x_mag_q <= mul_p[55:0];
				end else begin
					x_mag_q <= x_mag_q + {mul_p[23:0], 32'b0};
				end
			end
			ST_WMUL: begin
				unique case (step_q)
					3'd0: p_q <= 120'(mul_p);
					3'd1, 3'd2: p_q <= p_q + (120'(mul_p) << 32);
					default: p_q <= p_q + (120'(mul_p) << 64);
				endcase
			end
			ST_ACC: acc_q[term_q] <= acc_new;
			ST_DONE: begin
				if (out_free) begin
					result_q.target_index <= idx_q;
					result_q.e_x <= acc_q[0];
					result_q.e_y <= acc_q[1];
					result_q.e_z <= acc_q[2];
					result_q.b_x <= acc_q[3];
					result_q.b_y <= acc_q[4];
					result_q.b_z <= acc_q[5];
				end
			end
			default: ;
		endcase
	end

	// a source fetch never reaches past the count or onto the target itself
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> (j_q < n_q) && (j_q[ADDR_W-1:0] != tgt_addr_q))
		else $error("source fetch outside range or on target");

	// the square root of a Q0.64 value fits in 32 bits
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RS |-> sq_res_q[63:32] == '0)
		else $error("square root overflow");

	// the reciprocal never divides by zero
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RECIP |-> dv_q != '0)
		else $error("zero divisor");

	// a result appears only on leaving the done state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside done");

endmodule

FILE: test/pairwise_coulomb_biot_savart_field_sum_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the direct-sum Coulomb / Biot-Savart field unit.
// Stores and computes are predicted at acceptance by an in-bench fixed-point
// model of the field sum. Each result transaction is checked against the
// oldest pending prediction.
module pairwise_coulomb_biot_savart_field_sum_tb;
	import pcbs_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        result_valid;
	logic        result_stall;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	pairwise_coulomb_biot_savart_field_sum DUT (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the particle memory and configuration registers.
	logic [15:0]        pos_mem [3][MAX_PARTICLES];
	logic signed [31:0] vel_mem [3][MAX_PARTICLES];
	logic signed [15:0] charge_mem [MAX_PARTICLES];
	bit                 slot_written [MAX_PARTICLES];
	logic [12:0]        count_reg;
	logic [31:0]        floor_reg;
	logic [30:0]        clamp_reg;

	result_t field_q[$];
	int      mismatches;
	int      results_seen;
	int      computes_sent;
	int      stores_sent;
	int      send_idle_pct;
	int      recv_stall_pct;
	int      hold_cycles;

	always #2 clk = ~clk;

	// Stop a hung run.
	initial begin
		#20000000;
		$display("FAIL pairwise_coulomb_biot_savart_field_sum");
		$finish;
	end

	function automatic longint unsigned isqrt64(input longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// floor(2^80 / d), saturated to 64 bits
	function automatic longint unsigned inv_cube(input longint unsigned d);
		bit [127:0] q;
		q = (128'd1 << 80) / {64'd0, d};
		return (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
	endfunction

	function automatic longint unsigned magnitude(input longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	// sign(x) * min(2^63-1, |x| * w >> 23)
	function automatic longint weigh_term(input longint x, input longint unsigned w);
		bit [127:0] p;
		longint unsigned r;
		p = {64'd0, magnitude(x)} * {64'd0, w};
		p = p >> 23;
		r = (p > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : p[63:0];
		return x < 0 ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint sat_sum(input longint a, input longint b);
		longint s;
		s = a + b;
		if (a >= 0 && b > 0 && s < 0) return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (a < 0 && b < 0 && s >= 0) return 64'sh8000_0000_0000_0000;
		return s;
	endfunction

	function automatic longint shr16_trunc(input longint v);
		longint m;
		m = longint'(magnitude(v) >> 16);
		return v < 0 ? -m : m;
	endfunction

	function automatic longint clamp_speed(input longint v);
		longint c;
		c = longint'(clamp_reg);
		return v > c ? c : (v < -c ? -c : v);
	endfunction

	// Field sum at a target from every other source below the particle count.
	function automatic result_t field_sum(input logic [11:0] tgt);
		result_t r;
		longint acc [6];
		longint d [3];
		longint v [3];
		longint cr [3];
		longint unsigned sq, rr, ss, w;
		logic signed [15:0] sep;
		int n;
		acc = '{0, 0, 0, 0, 0, 0};
		n = count_reg > MAX_PARTICLES ? MAX_PARTICLES : int'(count_reg);
		for (int j = 0; j < n; j++) begin
			if (j == tgt) continue;
			sq = 0;
			for (int c = 0; c < 3; c++) begin
				sep = pos_mem[c][tgt] - pos_mem[c][j];
				d[c] = longint'(sep) * (1 << FRAC_SHIFT);
				sq += longint'(d[c] * d[c]);
				v[c] = clamp_speed(longint'(vel_mem[c][j]));
			end
			rr = sq >> 16;
			if (rr < floor_reg) rr = floor_reg;
			if (rr == 0) continue;
			ss = isqrt64(rr << 32);
			w = inv_cube(rr * ss);
			cr[0] = shr16_trunc(v[1] * d[2] - v[2] * d[1]);
			cr[1] = shr16_trunc(v[2] * d[0] - v[0] * d[2]);
			cr[2] = shr16_trunc(v[0] * d[1] - v[1] * d[0]);
			for (int c = 0; c < 3; c++) begin
				acc[c] = sat_sum(acc[c], weigh_term(longint'(charge_mem[j]) * d[c], w));
				acc[3 + c] = sat_sum(acc[3 + c],
					weigh_term(longint'(charge_mem[j]) * cr[c], w));
			end
		end
		r.target_index = tgt;
		r.e_x = acc[0]; r.e_y = acc[1]; r.e_z = acc[2];
		r.b_x = acc[3]; r.b_y = acc[4]; r.b_z = acc[5];
		return r;
	endfunction

	// Drive one item, wait for acceptance, update the shadow state.
	// Valid stays high after acceptance; the next call or the caller drops it.
	// Entered at a falling edge; stall is stable until the next rising edge.
	task automatic send_item(input item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid = 1'b0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
		end
		item_valid = 1'b1;
		item = it;
		while (item_stall) @(negedge clk);
		@(posedge clk);
		if (it.command == CMD_STORE) begin
			pos_mem[0][it.particle_index] = it.pos_x;
			pos_mem[1][it.particle_index] = it.pos_y;
			pos_mem[2][it.particle_index] = it.pos_z;
			vel_mem[0][it.particle_index] = it.vel_x;
			vel_mem[1][it.particle_index] = it.vel_y;
			vel_mem[2][it.particle_index] = it.vel_z;
			charge_mem[it.particle_index] = it.charge;
			slot_written[it.particle_index] = 1'b1;
			stores_sent++;
		end else begin
			field_q.push_back(field_sum(it.particle_index));
			computes_sent++;
		end
		@(negedge clk);
	endtask

	function automatic item_t random_item(input logic cmd, input logic [11:0] idx);
		item_t it;
		logic [223:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(item_t)-1:0];
		it.command = cmd;
		it.particle_index = idx;
		return it;
	endfunction

	task automatic store_particle(input logic [11:0] idx, input logic [15:0] x,
			input logic [15:0] y, input logic [15:0] z, input logic [31:0] v,
			input logic [15:0] q);
		item_t it;
		it = random_item(CMD_STORE, idx);
		it.pos_x = x; it.pos_y = y; it.pos_z = z;
		it.vel_x = v; it.vel_y = -v; it.vel_z = v ^ 32'h5A5A_5A5A;
		it.charge = q;
		send_item(it);
	endtask

	task automatic compute_at(input logic [11:0] idx);
		send_item(random_item(CMD_COMPUTE, idx));
	endtask

	// Wait until every result is back, then let the block settle.
	task automatic drain();
		item_valid = 1'b0;
		while (field_q.size() != 0) @(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		drain();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_PARTICLE_COUNT: count_reg = value[12:0];
			REG_SOFTENING_FLOOR: floor_reg = value;
			REG_SPEED_CLAMP: clamp_reg = value[30:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Receiver: a long hold-off when asked, random stalls otherwise.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			result_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic note_mismatch(input string name, input longint e, input longint a);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0d (0x%h) got %0d (0x%h)", name, e, e, a, a);
	endtask

	// Check every result transaction against the oldest prediction.
	always @(posedge clk) begin
		result_t e;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (field_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result for target %0d", result.target_index);
			end else begin
				e = field_q.pop_front();
				if (e.target_index !== result.target_index)
					note_mismatch("target_index", e.target_index, result.target_index);
				if (e.e_x !== result.e_x) note_mismatch("e_x", e.e_x, result.e_x);
				if (e.e_y !== result.e_y) note_mismatch("e_y", e.e_y, result.e_y);
				if (e.e_z !== result.e_z) note_mismatch("e_z", e.e_z, result.e_z);
				if (e.b_x !== result.b_x) note_mismatch("b_x", e.b_x, result.b_x);
				if (e.b_y !== result.b_y) note_mismatch("b_y", e.b_y, result.b_y);
				if (e.b_z !== result.b_z) note_mismatch("b_z", e.b_z, result.b_z);
			end
		end
	end

	// Extremes of position, velocity and charge, field signs, reset defaults,
	// zero count, coincident pair with zero floor, floor and clamp extremes.
	task automatic test_directed();
		compute_at(12'd0);                       // count zero: all fields zero
		write_reg(REG_PARTICLE_COUNT, 32'd3);
		store_particle(12'd0, 16'h0000, 16'h0000, 16'h0000, 32'h7FFF_FFFF, 16'h7FFF);
		store_particle(12'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h8000_0000, 16'h8000);
		store_particle(12'd2, 16'h8000, 16'h7FFF, 16'h0001, 32'h0001_0000, 16'h4000);
		compute_at(12'd0);
		compute_at(12'd1);
		compute_at(12'd2);
		// Coincident pair: slot 3 sits on slot 0.
		write_reg(REG_SOFTENING_FLOOR, 32'd0);
		store_particle(12'd3, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_0000, 16'h0001);
		write_reg(REG_PARTICLE_COUNT, 32'd4);
		compute_at(12'd0);
		compute_at(12'd3);
		write_reg(REG_SOFTENING_FLOOR, 32'hFFFF_FFFF);
		write_reg(REG_SPEED_CLAMP, 32'd0);
		compute_at(12'd1);
		write_reg(REG_SOFTENING_FLOOR, 32'd1);
		write_reg(REG_SPEED_CLAMP, 32'h7FFF_FFFF);
		compute_at(12'd2);
		compute_at(12'd1);
		// Target beyond the count still sums every source below it.
		store_particle(12'hFFF, 16'h1234, 16'hFEDC, 16'h8001, 32'h8000_0001, 16'hFFFF);
		compute_at(12'hFFF);
		drain();
	endtask

	// Well-formed populations with random content, then a mix of stores and computes.
	task automatic test_random_mix(input int items, input int send_pct, input int recv_pct);
		int cnt;
		int sent;
		logic [11:0] idx;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		sent = 0;
		while (sent < items) begin
			cnt = ($urandom_range(9) == 0) ? $urandom_range(24, 13) : $urandom_range(12, 1);
			write_reg(REG_PARTICLE_COUNT, cnt);
			case ($urandom_range(3))
				0: write_reg(REG_SOFTENING_FLOOR, $urandom);
				1: write_reg(REG_SOFTENING_FLOOR, $urandom_range(50000));
				default: ;
			endcase
			if ($urandom_range(2) == 0)
				write_reg(REG_SPEED_CLAMP, $urandom_range(1, 0) ? $urandom : $urandom_range(70000));
			for (int j = 0; j < cnt; j++)
				if (!slot_written[j] || $urandom_range(1) == 0) begin
					send_item(random_item(CMD_STORE, 12'(j)));
					sent++;
				end
			for (int k = 0; k < 8; k++) begin
				if ($urandom_range(3) == 0) begin
					send_item(random_item(CMD_STORE, 12'($urandom)));
				end else begin
					do idx = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(cnt - 1));
					while (!slot_written[idx]);
					compute_at(idx);
				end
				sent++;
			end
			drain();
		end
	endtask

	// Hold the receiver off while computes keep coming, so the input stalls.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_reg(REG_PARTICLE_COUNT, 32'd4);
		hold_cycles = 4000;
		for (int k = 0; k < 6; k++) compute_at(12'($urandom_range(3)));
		drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_PARTICLE_COUNT;
		cfg_data = '0;
		hold_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		results_seen = 0;
		computes_sent = 0;
		stores_sent = 0;
		count_reg = PARTICLE_COUNT_RST;
		floor_reg = SOFTENING_FLOOR_RST;
		clamp_reg = SPEED_CLAMP_RST;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_mix(25, 0, 0);
		test_random_mix(25, 56, 0);
		test_random_mix(25, 0, 56);
		test_random_mix(25, 22, 22);
		test_backpressure();

		drain();
		repeat (50) @(negedge clk);
		$display("Covered %0d stores and %0d computes (%0d results checked) across idle,",
			stores_sent, computes_sent, results_seen);
		$display("stall and hold-off phases, plus register extremes and coincident pairs.");
		if (mismatches == 0 && field_q.size() == 0) begin
			$display("PASS pairwise_coulomb_biot_savart_field_sum");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, field_q.size());
			$display("FAIL pairwise_coulomb_biot_savart_field_sum");
		end
		$finish;
	end

endmodule

FILE: pairwise_coulomb_biot_savart_field_sum.f
hdl/pcbs_pkg.sv
hdl/pcbs_ram.sv
hdl/pairwise_coulomb_biot_savart_field_sum.sv
test/pairwise_coulomb_biot_savart_field_sum_tb.sv
